[hw/rtl/kwm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and constants of the k-way sorted merge
// Command and result formats, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int ACT_W  = 4;   // width of the active list count register
  localparam int LIST_W = 3;   // width of a list number on the ports
  localparam int VAL_W  = 32;  // element width

  localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_TAKE   = 1'b1
  } op_t;

  // One classified input item as it waits for the back end.
  typedef struct packed {
    op_t                     op;
    logic                    drop;   // append to a list that does not exist
    logic [LIST_W-1:0]       list;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [LIST_W-1:0]       source_list;
    logic                    valid;
    logic                    list_full;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SCAN,
    ST_END
  } back_state_t;

endpackage

[hw/rtl/k_way_sorted_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge: k-way merge of sorted lists held in FIFOs
// Holds up to eight ascending lists, each a circular FIFO of DEPTH signed
// 32-bit values in one shared memory. An append stores a value at the tail
// of its list, or drops and flags it when the list is full or does not exist.
// A take returns the smallest head among the first active_lists lists, lowest
// list number on a tie, or a not-valid result when they are all empty. Items
// are taken one at a time by the execution unit; a take reads the heads of
// the first min(active_lists, LISTS, 8) lists one per cycle through the
// single read port of the element memory.
// Two-entry queues on both sides let input and output stall independently.
// The memory needs no clearing after reset; per-list counts reset to empty.
// Write active_lists only while the block is idle.
// ----------------------------------------------------------------------------
module k_way_sorted_merge
  import kwm_pkg::*;
#(
  parameter int LISTS = 8,
  parameter int DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic                    in_op,
  input  logic [LIST_W-1:0]       in_list_number,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic signed [VAL_W-1:0] out_value,
  output logic [LIST_W-1:0]       out_source_list,
  output logic                    out_valid,
  output logic                    out_list_full,
  input  logic                    cfg_wr_en,
  input  logic [ACT_W-1:0]        cfg_wr_data
);

  logic [ACT_W-1:0]        active_lists_r;
  cmd_t                    cmd;
  logic                    cmd_empty, cmd_pop;
  res_t                    res, res_out;
  logic                    res_push, res_full;
  logic [$bits(res_t)-1:0] res_bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_lists_r <= ACT_RESET;
    end else if (cfg_wr_en) begin
      active_lists_r <= cfg_wr_data;
    end
  end

  kwm_front #(
    .LISTS (LISTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_op          (in_op),
    .in_list_number (in_list_number),
    .in_value       (in_value),
    .cmd_pop        (cmd_pop),
    .cmd            (cmd),
    .cmd_empty      (cmd_empty)
  );

  kwm_back #(
    .LISTS (LISTS),
    .DEPTH (DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .active_lists (active_lists_r),
    .cmd          (cmd),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .res_space    (!res_full),
    .res_push     (res_push),
    .res          (res)
  );

  kwm_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_bits),
    .empty (out_empty)
  );

  assign res_out         = res_t'(res_bits);
  assign out_value       = res_out.value;
  assign out_source_list = res_out.source_list;
  assign out_valid       = res_out.valid;
  assign out_list_full   = res_out.list_full;

endmodule

[hw/rtl/kwm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/kwm_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_fifo: small register queue
// Push/full on the write side, pop/empty on the read side.
// ----------------------------------------------------------------------------
module kwm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

endmodule

[hw/rtl/kwm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_front: input side of the merge
// Decodes each input item, flags appends to missing lists, and queues it.
// ----------------------------------------------------------------------------
module kwm_front
  import kwm_pkg::*;
#(
  parameter int LISTS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic                     in_op,
  input  logic [LIST_W-1:0]        in_list_number,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic                     cmd_pop,
  output cmd_t                     cmd,
  output logic                     cmd_empty
);

  cmd_t                  cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_bits;

  always_comb begin
    cmd_in.op    = op_t'(in_op);
    cmd_in.list  = in_list_number;
    cmd_in.value = in_value;
    cmd_in.drop  = (int'(in_list_number) >= LISTS);
  end

  kwm_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (cmd_bits),
    .empty (cmd_empty)
  );

  assign cmd = cmd_t'(cmd_bits);

endmodule

[hw/rtl/kwm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_back: execution side of the merge
// Runs appends and takes one at a time against the list FIFOs in memory;
// a take scans the list heads one per cycle through the memory read port.
// ----------------------------------------------------------------------------
module kwm_back
  import kwm_pkg::*;
#(
  parameter int LISTS = 8,
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ACT_W-1:0]  active_lists,
  input  cmd_t              cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  logic              res_space,
  output logic              res_push,
  output res_t              res
);

  // Only lists reachable by a list number hold data.
  localparam int NL  = (LISTS < (1 << LIST_W)) ? LISTS : (1 << LIST_W);
  localparam int IW  = $clog2(NL);
  localparam int SW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW  = $clog2(DEPTH + 1);
  localparam int MD  = NL * DEPTH;
  localparam int AW  = $clog2(MD);

  back_state_t             state_r, state_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  logic [ACT_W-1:0]        i_r, i_nxt;
  logic                    found_r, found_nxt;
  logic signed [VAL_W-1:0] best_r, best_nxt;
  logic [IW-1:0]           best_idx_r, best_idx_nxt;
  logic                    p_v_r, p_v_nxt;
  logic [IW-1:0]           p_idx_r, p_idx_nxt;
  logic                    p_ne_r, p_ne_nxt;
  logic [SW-1:0]           rp_r [NL];
  logic [SW-1:0]           rp_nxt [NL];
  logic [FW-1:0]           fill_r [NL];
  logic [FW-1:0]           fill_nxt [NL];

  logic [ACT_W-1:0]        lim;
  logic [IW-1:0]           sel_idx;
  logic [SW-1:0]           sel_rp;
  logic [FW-1:0]           sel_fill;
  logic [FW:0]             wsum;
  logic [SW-1:0]           wslot;
  logic [AW-1:0]           base;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [VAL_W-1:0]        ram_rdata;

  assign lim = (active_lists > ACT_W'(NL)) ? ACT_W'(NL) : active_lists;

  always_comb begin
    unique case (state_r)
      ST_APPEND: sel_idx = cmd_r.list[IW-1:0];
      ST_SCAN:   sel_idx = i_r[IW-1:0];
      ST_END:    sel_idx = best_idx_r;
      default:   sel_idx = '0;
    endcase
  end

  assign sel_rp   = rp_r[sel_idx];
  assign sel_fill = fill_r[sel_idx];

  // Tail slot: head plus count, wrapped once.
  assign wsum  = (FW + 1)'(sel_rp) + (FW + 1)'(sel_fill);
  assign wslot = (wsum >= (FW + 1)'(DEPTH)) ? SW'(wsum - (FW + 1)'(DEPTH)) : SW'(wsum);

  assign base      = AW'(sel_idx) * AW'(DEPTH);
  assign ram_waddr = base + AW'(wslot);
  assign ram_raddr = base + AW'(sel_rp);

  kwm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MD)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd_r.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    i_nxt        = i_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    p_v_nxt      = 1'b0;
    p_idx_nxt    = p_idx_r;
    p_ne_nxt     = p_ne_r;
    rp_nxt       = rp_r;
    fill_nxt     = fill_r;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res          = '0;
    ram_we       = 1'b0;

    // Compare stage: head read issued in the previous cycle; strict less keeps the lower list.
    if (p_v_r && p_ne_r && (!found_r || ($signed(ram_rdata) < best_r))) begin
      found_nxt    = 1'b1;
      best_nxt     = $signed(ram_rdata);
      best_idx_nxt = p_idx_r;
    end

    unique case (state_r)
      ST_IDLE: begin
        // Start only with room for the result.
        if (!cmd_empty && res_space) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          if (cmd.op == OP_TAKE) begin
            i_nxt     = '0;
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_APPEND;
          end
        end
      end
      ST_APPEND: begin
        if (cmd_r.drop || (sel_fill == FW'(DEPTH))) begin
          res.list_full = 1'b1;
        end else begin
          ram_we            = 1'b1;
          fill_nxt[sel_idx] = sel_fill + 1'b1;
        end
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (i_r < lim) begin
          p_v_nxt   = 1'b1;
          p_idx_nxt = i_r[IW-1:0];
          p_ne_nxt  = (sel_fill != '0);
          i_nxt     = i_r + 1'b1;
        end else begin
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        if (found_r) begin
          rp_nxt[sel_idx]   = (sel_rp == SW'(DEPTH - 1)) ? '0 : sel_rp + 1'b1;
          fill_nxt[sel_idx] = sel_fill - 1'b1;
          res.value         = best_r;
          res.source_list   = LIST_W'(best_idx_r);
          res.valid         = 1'b1;
        end
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      found_r <= 1'b0;
      p_v_r   <= 1'b0;
      for (int k = 0; k < NL; k++) begin
        rp_r[k]   <= '0;
        fill_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      found_r <= found_nxt;
      p_v_r   <= p_v_nxt;
      rp_r    <= rp_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    p_idx_r    <= p_idx_nxt;
    p_ne_r     <= p_ne_nxt;
  end

endmodule

[hw/rtl/kwm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_props: port-level checks of the k-way sorted merge
// Watches the result channel and, after reset, the input queue; attached to the top level by bind.
// ----------------------------------------------------------------------------
module kwm_props
  import kwm_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_full,
  input logic                    out_empty,
  input logic                    out_pop,
  input logic signed [VAL_W-1:0] out_value,
  input logic [LIST_W-1:0]       out_source_list,
  input logic                    out_valid,
  input logic                    out_list_full
);

  // The result queue comes out of reset empty and the input queue not full.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // A result is never both a taken value and a dropped append.
  a_valid_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_valid && out_list_full))
    else $error("result both valid and full");

  // A result without a value carries zero value and list.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_valid) |-> (out_value == '0 && out_source_list == '0))
    else $error("non-valid result carries data");

  // Hold a waiting result until its transfer.
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_value) && $stable(out_source_list) &&
       $stable(out_valid) && $stable(out_list_full)))
    else $error("waiting result changed");

endmodule

bind k_way_sorted_merge kwm_props u_kwm_props (.*);

[tb/sv/kwm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_checker: result predictor and comparator for the k-way sorted merge
// Watches the input, result and configuration ports. It keeps its own copy of
// the list FIFOs and the active list count, works out the result of every
// accepted input item and compares each accepted result, field by field,
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module kwm_checker
  import kwm_pkg::*;
#(
  parameter int LISTS = 8,
  parameter int DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  input  logic                    in_full,
  input  logic                    in_op,
  input  logic [LIST_W-1:0]       in_list_number,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    out_empty,
  input  logic                    out_pop,
  input  logic signed [VAL_W-1:0] out_value,
  input  logic [LIST_W-1:0]       out_source_list,
  input  logic                    out_valid,
  input  logic                    out_list_full,
  input  logic                    cfg_wr_en,
  input  logic [ACT_W-1:0]        cfg_wr_data,
  output int                      errors,
  output int                      pending,
  output int                      taken,
  output int                      empty_takes,
  output int                      dropped
);

  logic signed [VAL_W-1:0] elem [LISTS][DEPTH];
  int                      head [LISTS];
  int                      fill [LISTS];
  logic [ACT_W-1:0]        act_lists;
  res_t                    merge_results_q [$];

  initial begin
    errors      = 0;
    pending     = 0;
    taken       = 0;
    empty_takes = 0;
    dropped     = 0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < 20) begin
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    end
    errors++;
  endtask

  // Apply one input item to the list copy and return the result it yields.
  function automatic res_t merge_step(op_t op, logic [LIST_W-1:0] lst,
                                      logic signed [VAL_W-1:0] v);
    res_t                    r;
    int                      n;
    int                      best;
    logic                    found;
    logic signed [VAL_W-1:0] best_v;
    r      = '0;
    found  = 1'b0;
    best   = 0;
    best_v = '0;
    if (op == OP_APPEND) begin
      if (lst >= LISTS || fill[lst] >= DEPTH) begin
        r.list_full = 1'b1;
        dropped++;
      end else begin
        elem[lst][(head[lst] + fill[lst]) % DEPTH] = v;
        fill[lst]++;
      end
    end else begin
      n = (act_lists > LISTS) ? LISTS : act_lists;
      // strict less-than keeps the lowest list number on equal heads
      for (int i = 0; i < n; i++) begin
        if (fill[i] != 0 && (!found || elem[i][head[i]] < best_v)) begin
          found  = 1'b1;
          best   = i;
          best_v = elem[i][head[i]];
        end
      end
      if (found) begin
        head[best]    = (head[best] + 1) % DEPTH;
        fill[best]--;
        r.value       = best_v;
        r.source_list = best[LIST_W-1:0];
        r.valid       = 1'b1;
        taken++;
      end else begin
        empty_takes++;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      for (int i = 0; i < LISTS; i++) begin
        head[i] = 0;
        fill[i] = 0;
      end
      act_lists = ACT_RESET;
      merge_results_q.delete();
    end else begin
      if (cfg_wr_en) begin
        act_lists = cfg_wr_data;
      end
      if (in_push && !in_full) begin
        merge_results_q.push_back(merge_step(op_t'(in_op), in_list_number, in_value));
      end
      if (out_pop && !out_empty) begin
        if (merge_results_q.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding", out_value, '0);
        end else begin
          want = merge_results_q.pop_front();
          if (out_value !== want.value)
            report_mismatch("out_value", out_value, want.value);
          if (out_source_list !== want.source_list)
            report_mismatch("out_source_list", out_source_list, want.source_list);
          if (out_valid !== want.valid)
            report_mismatch("out_valid", out_valid, want.valid);
          if (out_list_full !== want.list_full)
            report_mismatch("out_list_full", out_list_full, want.list_full);
        end
      end
    end
    pending = merge_results_q.size();
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the k-way sorted merge
// Drives a directed opening (extreme values, ties, empty takes, a full list)
// and then random phases of mostly ascending appends mixed with takes, each after
// an active list count write; channels idle at random but in one steady phase.
// ----------------------------------------------------------------------------
module testbench;
  import kwm_pkg::*;

  localparam int LISTS      = 8;
  localparam int DEPTH      = 16;
  localparam int PHASE_LEN  = 215;
  localparam int SETTLE     = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam logic signed [VAL_W-1:0] VMAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VMIN = 32'sh8000_0000;

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    in_push        = 1'b0;
  logic                    in_op          = 1'b0;
  logic [LIST_W-1:0]       in_list_number = '0;
  logic signed [VAL_W-1:0] in_value       = '0;
  logic                    out_pop        = 1'b0;
  logic                    cfg_wr_en      = 1'b0;
  logic [ACT_W-1:0]        cfg_wr_data    = '0;
  logic                    steady         = 1'b0;
  logic                    in_full;
  logic                    out_empty;
  logic signed [VAL_W-1:0] out_value;
  logic [LIST_W-1:0]       out_source_list;
  logic                    out_valid;
  logic                    out_list_full;

  int errors, pending, taken, empty_takes, dropped;
  int quiet_cycles = 0;
  int items_sent   = 0;
  logic signed [VAL_W-1:0] tail [LISTS];

  always #6 clk = ~clk;

  k_way_sorted_merge #(.LISTS(LISTS), .DEPTH(DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_op           (in_op),
    .in_list_number  (in_list_number),
    .in_value        (in_value),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_value       (out_value),
    .out_source_list (out_source_list),
    .out_valid       (out_valid),
    .out_list_full   (out_list_full),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  kwm_checker #(.LISTS(LISTS), .DEPTH(DEPTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_op           (in_op),
    .in_list_number  (in_list_number),
    .in_value        (in_value),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_value       (out_value),
    .out_source_list (out_source_list),
    .out_valid       (out_valid),
    .out_list_full   (out_list_full),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .errors          (errors),
    .pending         (pending),
    .taken           (taken),
    .empty_takes     (empty_takes),
    .dropped         (dropped)
  );

  // Result side: stall about a quarter of the cycles unless running steady.
  always @(posedge clk) begin
    out_pop <= steady || ($urandom_range(0, 99) >= 25);
  end

  // End the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item and hold it until the transfer.
  task automatic send(op_t op, logic [LIST_W-1:0] lst, logic signed [VAL_W-1:0] v);
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push        <= 1'b1;
    in_op          <= op;
    in_list_number <= lst;
    in_value       <= v;
    do @(posedge clk); while (in_full);
    items_sent++;
  endtask

  task automatic take_one();
    send(OP_TAKE, LIST_W'($urandom), $urandom);
  endtask

  // Drain all outstanding results, let the block settle, then write the count.
  task automatic drain_and_set(logic [ACT_W-1:0] count);
    in_push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(int count, bit tie_heavy);
    int                      take_pct;
    int                      step;
    logic [LIST_W-1:0]       lst;
    logic signed [VAL_W-1:0] v;
    take_pct = 50;
    // a shared start with tiny steps makes equal heads across lists common
    if (tie_heavy) begin
      v = $urandom;
      for (int i = 0; i < LISTS; i++) tail[i] = v;
    end
    for (int k = 0; k < count; k++) begin
      if (k % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       take_pct = 20;
          1:       take_pct = 50;
          default: take_pct = 80;
        endcase
      end
      if ($urandom_range(0, 99) < take_pct) begin
        take_one();
      end else begin
        lst = LIST_W'($urandom);
        if ($urandom_range(0, 9) == 0) begin
          v = $urandom;  // out of order on purpose
        end else begin
          step = tie_heavy ? $urandom_range(0, 3) : $urandom_range(0, 3000);
          if (tail[lst] > VMAX - step) tail[lst] = VMAX;
          else tail[lst] = tail[lst] + step;
          v = tail[lst];
        end
        send(OP_APPEND, lst, v);
      end
    end
  endtask

  initial begin
    logic [ACT_W-1:0] act_seq [8];
    act_seq = '{4'd3, 4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd8};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening at the reset count of eight lists
    take_one();
    send(OP_APPEND, 3'd0, VMIN);
    send(OP_APPEND, 3'd7, VMAX);
    send(OP_APPEND, 3'd2, 32'sd100);
    send(OP_APPEND, 3'd5, 32'sd100);
    repeat (5) take_one();
    for (int i = 0; i <= DEPTH; i++) begin
      send(OP_APPEND, 3'd4, VMIN + i * 32'sh0fff_ffff);
    end

    for (int i = 0; i < LISTS; i++) tail[i] = $urandom;
    for (int p = 0; p < 8; p++) begin
      drain_and_set(act_seq[p]);
      steady <= (p == 2);
      run_phase(PHASE_LEN, p % 2 == 1);
    end

    in_push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d items over 8 active-list settings (0, 1, 2, 3, 5, 8, 15).",
             items_sent);
    $display("Merged out %0d values, %0d takes found no list, %0d appends dropped.",
             taken, empty_takes, dropped);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_ram.sv
hw/rtl/kwm_fifo.sv
hw/rtl/kwm_front.sv
hw/rtl/kwm_back.sv
hw/rtl/k_way_sorted_merge.sv
hw/rtl/kwm_checker.sv
tb/sv/kwm_checker.sv
tb/sv/testbench.sv
